FILE: rtl/pfa_pkg.sv
// Shared types and constants for the page frame allocator.
package pfa_pkg;

    // Default number of page frames
    localparam int NUM_FRAMES_DEF = 32;

    // Fixed field widths of the stream items
    localparam int FUNC_W     = 4;
    localparam int FRAME_W    = 5;
    localparam int OWNER_W    = 8;
    localparam int HANDLE_W   = 16;
    localparam int COUNT_W    = 6;
    localparam int STAMP_W    = 32;
    localparam int BUDGET_W   = 6;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC       = 4'd0,
        FN_ALLOC_OWNER = 4'd1,
        FN_FREE        = 4'd2,
        FN_TEST        = 4'd3,
        FN_RESERVE     = 4'd4,
        FN_LRU         = 4'd5,
        FN_READ_OWNER  = 4'd6,
        FN_SET_OWNER   = 4'd7,
        FN_SET_STAMP   = 4'd8
    } func_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    // Input item as packed on the slave tdata, lowest field last
    typedef struct packed {
        logic                pad;
        logic [STAMP_W-1:0]  stamp;
        logic [COUNT_W-1:0]  page_count;
        logic [HANDLE_W-1:0] entry_handle;
        logic [OWNER_W-1:0]  owner_id;
        logic [FRAME_W-1:0]  frame_index;
        logic [FUNC_W-1:0]   func;
    } req_t;

    // Result item as packed on the master tdata, lowest field last
    typedef struct packed {
        logic                pad;
        logic [BUDGET_W-1:0] budget_left;
        logic                any_free;
        logic [HANDLE_W-1:0] handle_out;
        logic [OWNER_W-1:0]  owner_out;
        logic                is_used;
        logic                ok;
        logic                found;
        logic [FRAME_W-1:0]  frame_out;
    } res_t;

    // Running summary handed from cell to cell along the chain
    typedef struct packed {
        logic                free_found;
        logic [FRAME_W-1:0]  free_idx;
        logic                second_free;
        logic                best_valid;
        logic [STAMP_W-1:0]  best_stamp;
        logic [FRAME_W-1:0]  best_idx;
        logic                best_used;
        logic                hit_used;
        logic [OWNER_W-1:0]  hit_owner;
        logic [HANDLE_W-1:0] hit_handle;
    } carry_t;

    // Update command broadcast to every cell
    typedef struct packed {
        logic                commit;
        logic [FUNC_W-1:0]   func;
        logic [FRAME_W-1:0]  frame;
        logic [OWNER_W-1:0]  owner;
        logic [HANDLE_W-1:0] handle;
        logic [STAMP_W-1:0]  stamp;
    } cmd_t;

endpackage

FILE: rtl/pfa_cell.sv
// One page frame cell: holds the frame state and folds it into the passing summary.
module pfa_cell #(
    parameter int INDEX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  pfa_pkg::cmd_t   cmd,
    input  pfa_pkg::carry_t cin,
    output pfa_pkg::carry_t cout
);

    localparam logic                       HIT_OK  = (INDEX < (2 ** pfa_pkg::FRAME_W));
    localparam logic [pfa_pkg::FRAME_W-1:0] MY_IDX = pfa_pkg::FRAME_W'(INDEX);

    logic                         used_reg;
    logic                         used_next;
    logic [pfa_pkg::STAMP_W-1:0]  stamp_reg;
    logic [pfa_pkg::STAMP_W-1:0]  stamp_next;
    logic [pfa_pkg::OWNER_W-1:0]  owner_reg;
    logic [pfa_pkg::HANDLE_W-1:0] handle_reg;
    pfa_pkg::carry_t              carry_reg;
    pfa_pkg::carry_t              carry_next;

    logic hit;
    logic own_free;
    logic take_best;
    logic is_alloc;
    logic alloc_pick;
    logic owner_wr;

    assign hit       = HIT_OK && (cmd.frame == MY_IDX);
    assign own_free  = !used_reg;
    assign take_best = !cin.best_valid || (stamp_reg < cin.best_stamp);

    // Fold this frame into the summary
    always_comb
    begin
        carry_next             = cin;
        carry_next.free_found  = cin.free_found | own_free;
        carry_next.free_idx    = cin.free_found ? cin.free_idx : MY_IDX;
        carry_next.second_free = cin.second_free | (cin.free_found & own_free);
        if (take_best)
        begin
            carry_next.best_valid = 1'b1;
            carry_next.best_stamp = stamp_reg;
            carry_next.best_idx   = MY_IDX;
            carry_next.best_used  = used_reg;
        end
        if (hit)
        begin
            carry_next.hit_used   = used_reg;
            carry_next.hit_owner  = owner_reg;
            carry_next.hit_handle = handle_reg;
        end
    end

    // Decide the updates of this frame at commit
    assign is_alloc   = (cmd.func == pfa_pkg::FN_ALLOC) || (cmd.func == pfa_pkg::FN_ALLOC_OWNER);
    assign alloc_pick = own_free && !cin.free_found;
    assign owner_wr   = cmd.commit
                        && (((cmd.func == pfa_pkg::FN_ALLOC_OWNER) && alloc_pick)
                            || ((cmd.func == pfa_pkg::FN_SET_OWNER) && hit));

    always_comb
    begin
        used_next  = used_reg;
        stamp_next = stamp_reg;
        if (cmd.commit && is_alloc && alloc_pick)
        begin
            used_next = 1'b1;
        end
        else if (cmd.commit && (cmd.func == pfa_pkg::FN_FREE) && hit)
        begin
            used_next = 1'b0;
        end
        if (cmd.commit && (cmd.func == pfa_pkg::FN_SET_STAMP) && hit)
        begin
            stamp_next = cmd.stamp;
        end
    end

    // Used bit and timestamp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            stamp_reg <= '0;
        end
        else
        begin
            used_reg  <= used_next;
            stamp_reg <= stamp_next;
        end
    end

    // Owner, handle and summary stage
    always_ff @(posedge clk)
    begin
        if (owner_wr)
        begin
            owner_reg  <= cmd.owner;
            handle_reg <= cmd.handle;
        end
        carry_reg <= carry_next;
    end

    assign cout = carry_reg;

endmodule

FILE: rtl/page_frame_allocator_lru.sv
// Page frame allocator with least-recently-used victim choice, built as a chain of frame cells.
//
//   channel   dir  handshake            payload
//   s_*       in   s_tvalid / s_tready  s_tdata: request item (72 bits)
//   m_*       out  m_tvalid / m_tready  m_tdata: result item (40 bits)
//
// Each item is taken in the idle state, then the summary ripples through the cell chain
// (one cell per cycle) during the scan, and the update is committed in the commit state.
// Reset clears the used bits and timestamps and sets the budget to NUM_FRAMES at once; no sweep follows.
// A new item is taken while a result waits in the output register; commit holds
// until that register is free.
module page_frame_allocator_lru #(
    parameter int NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // func[3:0], frame_index[8:4], owner_id[16:9], entry_handle[32:17],
    // page_count[38:33], stamp[70:39], zero[71]
    input  logic [pfa_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // frame_out[4:0], found[5], ok[6], is_used[7], owner_out[15:8],
    // handle_out[31:16], any_free[32], budget_left[38:33], zero[39]
    output logic [pfa_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int CNT_W = $clog2(NUM_FRAMES);
    localparam int BUD_W = $clog2(NUM_FRAMES + 1);
    localparam int CMP_W = (BUD_W > pfa_pkg::BUDGET_W) ? BUD_W : pfa_pkg::BUDGET_W;

    pfa_pkg::state_t     state_reg;
    pfa_pkg::state_t     state_next;
    logic [CNT_W-1:0]    scan_cnt_reg;
    logic [CNT_W-1:0]    scan_cnt_next;
    logic [BUD_W-1:0]    budget_reg;
    logic [BUD_W-1:0]    budget_next;
    pfa_pkg::req_t       req_reg;
    pfa_pkg::req_t       req_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    pfa_pkg::res_t       out_data_reg;
    pfa_pkg::res_t       out_data_next;

    logic                accept;
    logic                scan_last;
    logic                commit_go;
    logic                fi_valid;
    logic                fits;
    logic [CMP_W-1:0]    count_ext;
    logic [CMP_W-1:0]    budget_ext;
    logic [CMP_W-1:0]    budget_after;
    pfa_pkg::cmd_t       cmd;
    pfa_pkg::carry_t     chain [0:NUM_FRAMES];
    pfa_pkg::carry_t     tail;
    pfa_pkg::res_t       res;

    assign scan_last = (scan_cnt_reg == CNT_W'(NUM_FRAMES - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfa_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = pfa_pkg::ST_SCAN;
                end
            end
            pfa_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = pfa_pkg::ST_COMMIT;
                end
            end
            pfa_pkg::ST_COMMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = pfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfa_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready      = 1'b0;
        commit_go     = 1'b0;
        scan_cnt_next = '0;
        case (state_reg)
            pfa_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            pfa_pkg::ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
            end
            pfa_pkg::ST_COMMIT:
            begin
                commit_go = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept   = s_tvalid && s_tready;
    assign req_next = accept ? pfa_pkg::req_t'(s_tdata) : req_reg;

    // Broadcast the request to the cells
    assign cmd.commit = commit_go;
    assign cmd.func   = req_reg.func;
    assign cmd.frame  = req_reg.frame_index;
    assign cmd.owner  = req_reg.owner_id;
    assign cmd.handle = req_reg.entry_handle;
    assign cmd.stamp  = req_reg.stamp;

    // Row of frame cells
    assign chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_FRAMES; gi++)
        begin : g_cell
            pfa_cell #(
                .INDEX (gi)
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd),
                .cin   (chain[gi]),
                .cout  (chain[gi+1])
            );
        end
    endgenerate

    assign tail = chain[NUM_FRAMES];

    // Reservation against the budget
    assign count_ext    = CMP_W'(req_reg.page_count);
    assign budget_ext   = CMP_W'(budget_reg);
    assign fits         = (count_ext <= budget_ext);
    assign budget_after = ((req_reg.func == pfa_pkg::FN_RESERVE) && fits)
                          ? (budget_ext - count_ext) : budget_ext;
    assign budget_next  = commit_go ? BUD_W'(budget_after) : budget_reg;

    assign fi_valid = (int'(req_reg.frame_index) < NUM_FRAMES);

    // Assemble the result item
    always_comb
    begin
        res             = '0;
        res.frame_out   = req_reg.frame_index;
        res.is_used     = tail.hit_used;
        res.any_free    = tail.free_found;
        res.budget_left = budget_after[pfa_pkg::BUDGET_W-1:0];
        case (req_reg.func)
            pfa_pkg::FN_ALLOC, pfa_pkg::FN_ALLOC_OWNER:
            begin
                // A failed search reports frame 0, which is then in use like every frame
                res.frame_out = tail.free_found ? tail.free_idx : '0;
                res.found     = tail.free_found;
                res.is_used   = 1'b1;
                res.any_free  = tail.second_free;
            end
            pfa_pkg::FN_FREE:
            begin
                res.is_used  = 1'b0;
                res.any_free = tail.free_found | fi_valid;
            end
            pfa_pkg::FN_RESERVE:
            begin
                res.ok = fits;
            end
            pfa_pkg::FN_LRU:
            begin
                res.frame_out = tail.best_idx;
                res.is_used   = tail.best_used;
            end
            pfa_pkg::FN_READ_OWNER:
            begin
                res.owner_out  = tail.hit_owner;
                res.handle_out = tail.hit_handle;
            end
            default:
            begin
                res.ok = 1'b0;
            end
        endcase
    end

    // Output register: load on commit, drop when taken
    assign out_valid_next = commit_go ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    assign out_data_next  = commit_go ? res : out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfa_pkg::ST_IDLE;
            scan_cnt_reg  <= '0;
            budget_reg    <= BUD_W'(NUM_FRAMES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            budget_reg    <= budget_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: rtl/pfa_checker.sv
// Port-level checks for the page frame allocator, bound to the top level.
module pfa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [pfa_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pfa_pkg::OUT_DATA_W-1:0] m_tdata
);

    pfa_pkg::res_t res;
    pfa_pkg::req_t req;

    assign res = m_tdata;
    assign req = s_tdata;

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // Drop ready for the scan after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new item taken during a scan");

    // A found frame is reported as used
    a_found_used: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !res.found || res.is_used)
        else $error("allocated frame not marked used");

    // Allocation and reservation never both succeed in one result
    a_found_ok_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(res.found && res.ok))
        else $error("found and ok both set");

    // Keep the unused request bit visible to the checker
    a_in_pad: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> (req.pad == 1'b0) || (req.pad == 1'b1))
        else $error("request pad bit unknown");

endmodule

bind page_frame_allocator_lru pfa_checker u_pfa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
